// ----- rtl/cipid_pkg.sv -----
package cipid_pkg;

   localparam int VAL_W   = 32;
   localparam int GAIN_W  = 16;
   localparam int LIMIT_W = 31;
   localparam int WHEEL_W = 2;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 31;

   localparam int MUL_A_W = GAIN_W + 1;
   localparam int MUL_B_W = VAL_W + 2;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int INC_W   = SUM_W - 8;
   localparam int ACC_W   = INC_W + 4;

   localparam logic [CSR_IDX_W-1:0] CSR_POS_GAIN_P = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_GAIN_I = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_GAIN_D = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_LIMIT  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_GAIN_P = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_GAIN_I = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_GAIN_D = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_LIMIT  = 4'd7;

   localparam logic [1:0] MUL_SPEED = 2'd0;
   localparam logic [1:0] MUL_P     = 2'd1;
   localparam logic [1:0] MUL_I     = 2'd2;
   localparam logic [1:0] MUL_D     = 2'd3;

   typedef struct packed {
      logic [WHEEL_W-1:0]      wheel;
      logic signed [VAL_W-1:0] position_reference;
      logic signed [VAL_W-1:0] measured_position;
      logic signed [VAL_W-1:0] measured_speed;
   } req_item_type;

   typedef struct packed {
      logic [WHEEL_W-1:0]      wheel_out;
      logic signed [VAL_W-1:0] drive_command;
   } rsp_item_type;

   typedef struct packed {
      logic       start;
      logic       loop_vel;
      logic       err_en;
      logic       diff_en;
      logic [1:0] mul_op;
      logic       sum_clr;
      logic       sum_en;
      logic       add_en;
      logic       wr_en;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic in_range;
   } status_type;

   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) begin
         return 32'sh7fffffff;
      end else if (v < lo) begin
         return 32'sh80000000;
      end
      return v[VAL_W-1:0];
   endfunction

endpackage

// ----- rtl/cipid_ctrl.sv -----
module cipid_ctrl
   import cipid_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ERR   = 4'd1;
   localparam logic [3:0] ST_DIFF  = 4'd2;
   localparam logic [3:0] ST_MUL0  = 4'd3;
   localparam logic [3:0] ST_MUL1  = 4'd4;
   localparam logic [3:0] ST_MUL2  = 4'd5;
   localparam logic [3:0] ST_MUL3  = 4'd6;
   localparam logic [3:0] ST_ADD   = 4'd7;
   localparam logic [3:0] ST_CLAMP = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       loop_vel_ff, loop_vel_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      loop_vel_in = loop_vel_ff;
      cmd         = '0;
      cmd.loop_vel = loop_vel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.start   = 1'b1;
               loop_vel_in = 1'b0;
               state_in    = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.err_en = 1'b1;
            cmd.mul_op = MUL_SPEED;
            state_in   = status.in_range ? ST_DIFF : ST_DONE;
         end
         ST_DIFF: begin
            cmd.diff_en = 1'b1;
            state_in    = ST_MUL0;
         end
         ST_MUL0: begin
            cmd.mul_op  = MUL_P;
            cmd.sum_clr = 1'b1;
            state_in    = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_op = MUL_I;
            cmd.sum_en = 1'b1;
            state_in   = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_op = MUL_D;
            cmd.sum_en = 1'b1;
            state_in   = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            cmd.add_en = 1'b1;
            state_in   = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.wr_en = 1'b1;
            if (loop_vel_ff) begin
               state_in = ST_DONE;
            end else begin
               loop_vel_in = 1'b1;
               state_in    = ST_ERR;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loop_vel_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loop_vel_ff  <= loop_vel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/cipid_datapath.sv -----
module cipid_datapath
   import cipid_pkg::*;
#(
   parameter int WHEELS      = 4,
   parameter int SPEED_SCALE = 36
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_item_type          req_item,
   output rsp_item_type          rsp_item,
   input  cmd_type               cmd,
   output status_type            status
);

   localparam int IDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;

   logic [GAIN_W-1:0]  pos_kp_ff, pos_ki_ff, pos_kd_ff;
   logic [GAIN_W-1:0]  vel_kp_ff, vel_ki_ff, vel_kd_ff;
   logic [LIMIT_W-1:0] pos_limit_ff, vel_limit_ff;

   req_item_type            item_ff;
   rsp_item_type            rsp_ff;
   logic signed [VAL_W-1:0] err_ff, err_in;
   logic signed [VAL_W:0]   d1_ff, d1_in;
   logic signed [VAL_W+1:0] d2_ff, d2_in;
   logic signed [VAL_W-1:0] vfb_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [VAL_W-1:0] loop_out_ff, clamp_in;

   logic signed [VAL_W-1:0] last_ff  [2][WHEELS];
   logic signed [VAL_W-1:0] older_ff [2][WHEELS];
   logic signed [VAL_W-1:0] accum_ff [2][WHEELS];

   logic [4:0]              wheel_wide;
   logic [IDX_W-1:0]        idx;
   logic                    lp;
   logic signed [VAL_W-1:0] e1, e2, accum_rd, ref_v, fdb_v;
   logic [GAIN_W-1:0]       kp, ki, kd;
   logic [LIMIT_W-1:0]      limit;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [INC_W-1:0] inc;
   logic signed [ACC_W-1:0] lim_pos, lim_neg;

   assign wheel_wide      = {3'b000, item_ff.wheel};
   assign idx             = wheel_wide[IDX_W-1:0];
   assign status.in_range = ({27'd0, wheel_wide} < 32'(WHEELS));
   assign lp              = cmd.loop_vel;

   assign e1       = last_ff[lp][idx];
   assign e2       = older_ff[lp][idx];
   assign accum_rd = accum_ff[lp][idx];

   assign kp    = lp ? vel_kp_ff : pos_kp_ff;
   assign ki    = lp ? vel_ki_ff : pos_ki_ff;
   assign kd    = lp ? vel_kd_ff : pos_kd_ff;
   assign limit = lp ? vel_limit_ff : pos_limit_ff;

   assign ref_v = lp ? loop_out_ff : item_ff.position_reference;
   assign fdb_v = lp ? vfb_ff : item_ff.measured_position;

   assign err_in = sat32(64'(ref_v) - 64'(fdb_v));
   assign d1_in  = {err_ff[VAL_W-1], err_ff} - {e1[VAL_W-1], e1};
   assign d2_in  = {{2{err_ff[VAL_W-1]}}, err_ff} - {e1[VAL_W-1], e1, 1'b0}
                 + {{2{e2[VAL_W-1]}}, e2};

   always_comb begin
      unique case (cmd.mul_op)
         MUL_SPEED: begin
            mul_a = MUL_A_W'(SPEED_SCALE);
            mul_b = {{2{item_ff.measured_speed[VAL_W-1]}}, item_ff.measured_speed};
         end
         MUL_P: begin
            mul_a = {1'b0, kp};
            mul_b = {d1_ff[VAL_W], d1_ff};
         end
         MUL_I: begin
            mul_a = {1'b0, ki};
            mul_b = {{2{err_ff[VAL_W-1]}}, err_ff};
         end
         MUL_D: begin
            mul_a = {1'b0, kd};
            mul_b = d2_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   assign inc     = INC_W'(sum_ff >>> 8);
   assign acc_in  = {{(ACC_W-VAL_W){accum_rd[VAL_W-1]}}, accum_rd}
                  + {{(ACC_W-INC_W){inc[INC_W-1]}}, inc};
   assign lim_pos = {{(ACC_W-LIMIT_W){1'b0}}, limit};
   assign lim_neg = -lim_pos;

   always_comb begin
      if (acc_ff > lim_pos) begin
         clamp_in = VAL_W'(lim_pos);
      end else if (acc_ff < lim_neg) begin
         clamp_in = VAL_W'(lim_neg);
      end else begin
         clamp_in = VAL_W'(acc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_kp_ff    <= '0;
         pos_ki_ff    <= '0;
         pos_kd_ff    <= '0;
         pos_limit_ff <= '0;
         vel_kp_ff    <= '0;
         vel_ki_ff    <= '0;
         vel_kd_ff    <= '0;
         vel_limit_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_POS_GAIN_P: pos_kp_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_POS_GAIN_I: pos_ki_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_POS_GAIN_D: pos_kd_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_POS_LIMIT:  pos_limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_VEL_GAIN_P: vel_kp_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_VEL_GAIN_I: vel_ki_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_VEL_GAIN_D: vel_kd_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_VEL_LIMIT:  vel_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // per-wheel loop history
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < 2; l++) begin
            for (int w = 0; w < WHEELS; w++) begin
               last_ff[l][w]  <= '0;
               older_ff[l][w] <= '0;
               accum_ff[l][w] <= '0;
            end
         end
      end else if (cmd.wr_en) begin
         older_ff[lp][idx] <= e1;
         last_ff[lp][idx]  <= err_ff;
         accum_ff[lp][idx] <= clamp_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.start) begin
         item_ff     <= req_item;
         loop_out_ff <= '0;
      end
      if (cmd.err_en) begin
         err_ff <= err_in;
      end
      if (cmd.diff_en) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
         if (!lp) begin
            vfb_ff <= sat32({{(64-PROD_W){prod_ff[PROD_W-1]}}, prod_ff});
         end
      end
      if (cmd.sum_clr) begin
         sum_ff <= '0;
      end else if (cmd.sum_en) begin
         sum_ff <= sum_ff + {prod_ff[PROD_W-1], prod_ff};
      end
      if (cmd.add_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.wr_en) begin
         loop_out_ff <= clamp_in;
      end
      if (cmd.rsp_load) begin
         rsp_ff.wheel_out     <= item_ff.wheel;
         rsp_ff.drive_command <= loop_out_ff;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

// ----- rtl/cascaded_incremental_pid_unit.sv -----
// channel   handshake              payload
// req       req_valid / req_stall  req_item (wheel, references, measurements)
// rsp       rsp_valid / rsp_stall  rsp_item (wheel_out, drive_command)
// csr       csr_write              csr_index, csr_wdata
//
// One item at a time: accept, eight steps per loop on the shared 17x34
// multiplier (error, differences, four multiply and sum steps, add, clamp),
// then a done step loads the output register. A wheel out of range skips to
// done. Synchronous reset clears gains, limits and all wheel history.
// A stalled result sits in the output register while the next item is taken.
module cascaded_incremental_pid_unit
   import cipid_pkg::*;
#(
   parameter int WHEELS      = 4,
   parameter int SPEED_SCALE = 36
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   cipid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cipid_datapath #(
      .WHEELS      (WHEELS),
      .SPEED_SCALE (SPEED_SCALE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
